// File: rtl/core/mi3_pkg.sv
`default_nettype none
package mi3_pkg;
    localparam int DataW     = 16;
    localparam int Lanes     = 9;
    localparam int ProdW     = 2 * DataW;
    localparam int AdjW      = ProdW + 1;
    localparam int MagW      = ProdW;
    localparam int TermW     = DataW + AdjW;
    localparam int DetW      = TermW + 1;
    localparam int DetMagW   = 48;
    localparam int ThrW      = 16;
    localparam int ThrShift  = 24;
    localparam int InvW      = 32;
    localparam int QW        = 34;
    localparam int DivSteps  = QW;
    localparam int PreShift  = 5;
    localparam int FrontStages = 5;
    localparam int PipeDepth = FrontStages + 1 + DivSteps + 1;
    localparam int AddrW     = 3;

    localparam logic RegDetThreshold = 1'b0;
    localparam logic [ThrW-1:0] ThrReset = 16'd1;

    typedef logic signed [DataW-1:0] elem_t;

    typedef struct packed {
        logic [QW-1:0] quot;
        logic          ovf;
        logic          neg;
    } lane_res_t;
endpackage
`default_nettype wire

// File: rtl/core/mi3_front.sv
`default_nettype none
module mi3_front (
    input  wire logic                     aclk,
    input  wire logic                     ce,
    input  wire logic [mi3_pkg::ThrW-1:0] thr,
    input  wire mi3_pkg::elem_t           a_in [mi3_pkg::Lanes],
    output logic [mi3_pkg::MagW-1:0]      adj_mag [mi3_pkg::Lanes],
    output logic                          adj_neg [mi3_pkg::Lanes],
    output logic [mi3_pkg::DetMagW-1:0]   det_mag,
    output logic                          det_neg,
    output logic                          singular
);
    import mi3_pkg::*;

    logic signed [ProdW-1:0] pp_reg [Lanes];
    logic signed [ProdW-1:0] pn_reg [Lanes];
    logic signed [ProdW-1:0] pp_next [Lanes];
    logic signed [ProdW-1:0] pn_next [Lanes];
    elem_t                   row1_reg [3];
    elem_t                   row2_reg [3];
    logic signed [AdjW-1:0]  adj2_reg [Lanes];
    logic signed [AdjW-1:0]  adj3_reg [Lanes];
    logic signed [AdjW-1:0]  adj4_reg [Lanes];
    logic signed [TermW-1:0] term_reg [3];
    logic signed [DetW-1:0]  det_reg;

    // Cofactor (c, r) lands at adjugate position (r, c).
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            assign pp_next[r*3+c] = a_in[C1*3+R1] * a_in[C2*3+R2];
            assign pn_next[r*3+c] = a_in[C1*3+R2] * a_in[C2*3+R1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < Lanes; i++) begin
                pp_reg[i]   <= pp_next[i];
                pn_reg[i]   <= pn_next[i];
                adj2_reg[i] <= {pp_reg[i][ProdW-1], pp_reg[i]} - {pn_reg[i][ProdW-1], pn_reg[i]};
                adj3_reg[i] <= adj2_reg[i];
                adj4_reg[i] <= adj3_reg[i];
                adj_mag[i]  <= adj4_reg[i][AdjW-1] ? MagW'(-adj4_reg[i]) : MagW'(adj4_reg[i]);
                adj_neg[i]  <= adj4_reg[i][AdjW-1];
            end
            for (int j = 0; j < 3; j++) begin
                row1_reg[j] <= a_in[j];
                row2_reg[j] <= row1_reg[j];
                term_reg[j] <= row2_reg[j] * adj2_reg[j*3];
            end
            det_reg  <= {term_reg[0][TermW-1], term_reg[0]}
                      + {term_reg[1][TermW-1], term_reg[1]}
                      + {term_reg[2][TermW-1], term_reg[2]};
            det_mag  <= det_reg[DetW-1] ? DetMagW'(-det_reg) : DetMagW'(det_reg);
            det_neg  <= det_reg[DetW-1];
            // A zero determinant is singular even with the threshold at zero.
            singular <= (det_reg == '0) ||
                        ((det_reg[DetW-1] ? DetMagW'(-det_reg) : DetMagW'(det_reg))
                         < DetMagW'({thr, {ThrShift{1'b0}}}));
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/mi3_div.sv
`default_nettype none
module mi3_div (
    input  wire logic                     aclk,
    input  wire logic                     ce,
    input  wire logic [mi3_pkg::MagW-1:0] adj_mag [mi3_pkg::Lanes],
    input  wire logic                     adj_neg [mi3_pkg::Lanes],
    input  wire logic [mi3_pkg::DetMagW-1:0] det_mag,
    input  wire logic                     det_neg,
    input  wire logic                     singular_in,
    output mi3_pkg::lane_res_t            res [mi3_pkg::Lanes],
    output logic                          singular_out
);
    import mi3_pkg::*;

    // Quotient of |adj| * 2^29 / |det|, one bit per stage, restoring.
    logic [DetMagW-1:0]  rem_reg  [DivSteps+1][Lanes];
    logic [QW-1:0]       quot_reg [DivSteps+1][Lanes];
    logic [PreShift-1:0] low_reg  [DivSteps+1][Lanes];
    logic                ovf_reg  [DivSteps+1][Lanes];
    logic                neg_reg  [DivSteps+1][Lanes];
    logic [DetMagW-1:0]  den_reg  [DivSteps+1];
    logic                sing_reg [DivSteps+1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            den_reg[0]  <= det_mag;
            sing_reg[0] <= singular_in;
            for (int i = 0; i < Lanes; i++) begin
                rem_reg[0][i]  <= DetMagW'(adj_mag[i] >> PreShift);
                quot_reg[0][i] <= '0;
                low_reg[0][i]  <= adj_mag[i][PreShift-1:0];
                // The quotient would not fit in QW bits: saturates anyway.
                ovf_reg[0][i]  <= {{(DetMagW-MagW+PreShift){1'b0}}, adj_mag[i]}
                                  >= {det_mag, {PreShift{1'b0}}};
                neg_reg[0][i]  <= adj_neg[i] ^ det_neg;
            end
        end
    end

    for (genvar s = 0; s < DivSteps; s++) begin : g_step
        logic [DetMagW:0]   shifted [Lanes];
        logic               fits    [Lanes];
        always_comb begin
            for (int i = 0; i < Lanes; i++) begin
                shifted[i] = {rem_reg[s][i], low_reg[s][i][PreShift-1]};
                fits[i]    = shifted[i] >= {1'b0, den_reg[s]};
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                den_reg[s+1]  <= den_reg[s];
                sing_reg[s+1] <= sing_reg[s];
                for (int i = 0; i < Lanes; i++) begin
                    rem_reg[s+1][i]  <= fits[i] ? DetMagW'(shifted[i] - {1'b0, den_reg[s]})
                                                : DetMagW'(shifted[i]);
                    quot_reg[s+1][i] <= {quot_reg[s][i][QW-2:0], fits[i]};
                    low_reg[s+1][i]  <= {low_reg[s][i][PreShift-2:0], 1'b0};
                    ovf_reg[s+1][i]  <= ovf_reg[s][i];
                    neg_reg[s+1][i]  <= neg_reg[s][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            res[i].quot = quot_reg[DivSteps][i];
            res[i].ovf  = ovf_reg[DivSteps][i];
            res[i].neg  = neg_reg[DivSteps][i];
        end
    end
    assign singular_out = sing_reg[DivSteps];
endmodule
`default_nettype wire

// File: rtl/core/matrix_inverse_3x3.sv
// An accepted request passes the front stages, the divider and the output register to the master side.
// Throughput: one matrix per cycle while the master side does not stall; the 34-stage
// restoring divider, one quotient bit per stage in each of nine lanes, sets the pipeline depth.
// A stall on the master side halts the whole pipeline and the slave side together.
// Reset (aresetn low, synchronous) clears all valid bits and sets det_threshold to 1.
`default_nettype none
module matrix_inverse_3x3 (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22 from bit 0 up
    input  wire logic [143:0]              s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22 from bit 0 up
    output logic [287:0]                   m_axis_tdata,
    // singular, saturated from bit 0 up
    output logic [1:0]                     m_axis_tuser,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mi3_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mi3_pkg::*;

    logic [ThrW-1:0]      thr_reg;
    logic [PipeDepth-2:0] valid_reg;
    logic                 ce;
    elem_t                a_in [Lanes];
    logic [MagW-1:0]      adj_mag [Lanes];
    logic                 adj_neg [Lanes];
    logic [DetMagW-1:0]   det_mag;
    logic                 det_neg;
    logic                 front_sing;
    lane_res_t            res [Lanes];
    logic                 div_sing;
    logic                 m_valid_reg;
    logic [287:0]         m_data_reg;
    logic [287:0]         m_data_next;
    logic [1:0]           m_user_reg;
    logic                 sat_any;
    logic [QW-1:0]        q_round [Lanes];
    logic                 sat_lane [Lanes];

    assign pready = 1'b1;
    assign prdata = (paddr[AddrW-1] == RegDetThreshold) ? 32'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= ThrReset;
        end else if (psel && penable && pwrite && (paddr[AddrW-1] == RegDetThreshold)) begin
            thr_reg <= pwdata[ThrW-1:0];
        end
    end

    assign ce            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    for (genvar i = 0; i < Lanes; i++) begin : g_unpack
        assign a_in[i] = s_axis_tdata[i*DataW +: DataW];
    end

    mi3_front u_front (
        .aclk     (aclk),
        .ce       (ce),
        .thr      (thr_reg),
        .a_in     (a_in),
        .adj_mag  (adj_mag),
        .adj_neg  (adj_neg),
        .det_mag  (det_mag),
        .det_neg  (det_neg),
        .singular (front_sing)
    );

    mi3_div u_div (
        .aclk         (aclk),
        .ce           (ce),
        .adj_mag      (adj_mag),
        .adj_neg      (adj_neg),
        .det_mag      (det_mag),
        .det_neg      (det_neg),
        .singular_in  (front_sing),
        .res          (res),
        .singular_out (div_sing)
    );

    // Round half away from zero, then clip to the signed 32-bit range; a singular matrix gives zero in every lane.
    always_comb begin
        sat_any = 1'b0;
        for (int i = 0; i < Lanes; i++) begin
            q_round[i]  = QW'(({1'b0, res[i].quot} + 1'b1) >> 1);
            sat_lane[i] = res[i].ovf ||
                          (res[i].neg ? (q_round[i] > QW'(34'h0_8000_0000))
                                      : (q_round[i] > QW'(34'h0_7FFF_FFFF)));
            if (div_sing) begin
                m_data_next[i*InvW +: InvW] = '0;
            end else if (res[i].neg) begin
                m_data_next[i*InvW +: InvW] = sat_lane[i] ? 32'h8000_0000
                                                          : InvW'(-q_round[i]);
            end else begin
                m_data_next[i*InvW +: InvW] = sat_lane[i] ? 32'h7FFF_FFFF
                                                          : q_round[i][InvW-1:0];
            end
            sat_any = sat_any | sat_lane[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg   <= {valid_reg[PipeDepth-3:0], s_axis_tvalid};
            m_valid_reg <= valid_reg[PipeDepth-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= m_data_next;
            m_user_reg <= {!div_sing && sat_any, div_sing};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
endmodule
`default_nettype wire
